// ----- rtl/eui_pkg.sv -----
// Shared types and codes for the EHABI unwind interpreter.
package eui_pkg;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] frame_fp;
        logic [31:0] frame_sp;
        logic [31:0] frame_lr;
        logic [31:0] frame_pc;
        logic [31:0] stack_top;
        logic [31:0] index_word;
        logic [31:0] index_entry_addr;
        logic [31:0] mem_word;
    } eui_in_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] read_addr;
        logic [31:0] new_fp;
        logic [31:0] new_sp;
        logic [31:0] new_lr;
        logic [31:0] new_pc;
        logic [2:0]  fail_code;
    } eui_out_t;

    typedef struct packed {
        logic        en;
        logic        thumb;
        logic [31:0] fp;
        logic [31:0] sp;
        logic [31:0] lr;
    } rf_start_t;

    typedef struct packed {
        logic        en;
        logic [3:0]  addr;
        logic [31:0] data;
    } rf_wr_t;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_INDEX = 2'd1;
    localparam logic [1:0] CMD_MEM   = 2'd2;

    localparam logic [1:0] RK_READ  = 2'd0;
    localparam logic [1:0] RK_FRAME = 2'd1;
    localparam logic [1:0] RK_FAIL  = 2'd2;

    localparam logic [2:0] FC_CANNOT     = 3'd0;
    localparam logic [2:0] FC_BAD_INDEX  = 3'd1;
    localparam logic [2:0] FC_BAD_PERS   = 3'd2;
    localparam logic [2:0] FC_REFUSE     = 3'd3;
    localparam logic [2:0] FC_SPARE      = 3'd4;
    localparam logic [2:0] FC_UNHANDLED  = 3'd5;
    localparam logic [2:0] FC_SP_RANGE   = 3'd6;
    localparam logic [2:0] FC_PC_SAME    = 3'd7;

    localparam logic [3:0] REG_FP_THUMB = 4'd7;
    localparam logic [3:0] REG_FP_ARM   = 4'd11;
    localparam logic [3:0] REG_SP       = 4'd13;
    localparam logic [3:0] REG_LR       = 4'd14;
    localparam logic [3:0] REG_PC       = 4'd15;

    localparam logic [7:0] OP_FINISH   = 8'hb0;
    localparam logic [7:0] OP_POP_LOW  = 8'hb1;
    localparam logic [7:0] OP_VSP_LONG = 8'hb2;

endpackage

// ----- rtl/eui_regfile.sv -----
// Sixteen-entry virtual register file with start load and one write port.
module eui_regfile (
    input  logic                 clk,
    input  logic                 rst_n,
    input  eui_pkg::rf_start_t   start,
    input  eui_pkg::rf_wr_t      wr,
    input  logic [3:0]           rd_addr,
    output logic [31:0]          rd_data,
    output logic [31:0]          r13,
    output logic [31:0]          r14,
    output logic [31:0]          r15
);
    import eui_pkg::*;

    logic [31:0] regs_reg [16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                regs_reg[i] <= '0;
        end
        else if (start.en)
        begin
            for (int i = 0; i < 16; i++)
                regs_reg[i] <= '0;
            regs_reg[start.thumb ? REG_FP_THUMB : REG_FP_ARM] <= start.fp;
            regs_reg[REG_SP] <= start.sp;
            regs_reg[REG_LR] <= start.lr;
        end
        else if (wr.en)
        begin
            regs_reg[wr.addr] <= wr.data;
        end
    end

    assign rd_data = regs_reg[rd_addr];
    assign r13     = regs_reg[REG_SP];
    assign r14     = regs_reg[REG_LR];
    assign r15     = regs_reg[REG_PC];

endmodule

// ----- rtl/eui_seq.sv -----
// Bytecode sequencer: decodes commands and unwind opcodes around one shared adder.
module eui_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  eui_pkg::eui_in_t     in_data,
    output logic                 res_valid,
    input  logic                 res_take,
    output eui_pkg::eui_out_t    res,
    output eui_pkg::rf_start_t   rf_start,
    output eui_pkg::rf_wr_t      rf_wr,
    output logic [3:0]           rd_addr,
    input  logic [31:0]          rd_data,
    input  logic [31:0]          r13,
    input  logic [31:0]          r14,
    input  logic [31:0]          r15
);
    import eui_pkg::*;

    typedef enum logic [3:0] {
        C_WAIT, C_BEGIN, C_FETCH, C_DISPATCH, C_ARG, C_POP, C_DONE, C_COMPLETE, C_EMIT
    } ctl_t;

    typedef enum logic [2:0] {
        PH_IDLE, PH_INDEX, PH_FIRST, PH_OPWORD, PH_ARGWORD, PH_POP
    } phase_t;

    ctl_t        ctl_reg, ctl_next;
    phase_t      phase_reg, phase_next;
    logic [31:0] cur_reg, cur_next;
    logic [1:0]  bp_reg, bp_next;
    logic [8:0]  wl_reg, wl_next;
    logic [31:0] tra_reg, tra_next;
    logic [31:0] vsp_reg, vsp_next;
    logic [11:0] pm_reg, pm_next;
    logic [3:0]  pr_reg, pr_next;
    logic [7:0]  op_reg, op_next;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] hi_reg, hi_next;
    logic [3:0]  fpidx_reg, fpidx_next;
    logic [31:0] epc_reg, epc_next;
    eui_out_t    res_reg, res_next;

    logic [31:0] add_a, add_b, add_sum;
    logic        add_ci;

    logic [7:0]  nb_byte;
    logic        nb_fetch;
    logic [8:0]  nb_wl;
    logic [1:0]  nb_bp;
    logic [7:0]  arg_b;
    logic [31:0] pc_eff;
    logic        in_acc;

    function automatic eui_out_t mk_read(input logic [31:0] addr);
        eui_out_t r;
        r = '0;
        r.result_kind = RK_READ;
        r.read_addr = addr;
        return r;
    endfunction

    function automatic eui_out_t mk_fail(input logic [2:0] code);
        eui_out_t r;
        r = '0;
        r.result_kind = RK_FAIL;
        r.fail_code = code;
        return r;
    endfunction

    assign add_sum  = add_a + add_b + {31'b0, add_ci};
    assign in_ready = (ctl_reg == C_WAIT);
    assign in_acc   = in_valid && in_ready;
    assign res_valid = (ctl_reg == C_EMIT);
    assign res      = res_reg;
    assign arg_b    = pm_reg[7:0];
    assign pc_eff   = (r15 == 32'd0) ? r14 : r15;

    // next bytecode byte, most significant first
    always_comb
    begin
        nb_byte  = 8'd0;
        nb_fetch = 1'b0;
        nb_wl    = wl_reg;
        nb_bp    = bp_reg;
        if (wl_reg != 9'd0)
        begin
            case (bp_reg)
                2'd0:    nb_byte = cur_reg[7:0];
                2'd1:    nb_byte = cur_reg[15:8];
                2'd2:    nb_byte = cur_reg[23:16];
                default: nb_byte = cur_reg[31:24];
            endcase
            if (bp_reg == 2'd0)
            begin
                nb_wl = wl_reg - 9'd1;
                if (nb_wl != 9'd0)
                    nb_fetch = 1'b1;
                else
                    nb_bp = 2'd3;
            end
            else
            begin
                nb_bp = bp_reg - 2'd1;
            end
        end
    end

    always_comb
    begin
        ctl_next   = ctl_reg;
        phase_next = phase_reg;
        cur_next   = cur_reg;
        bp_next    = bp_reg;
        wl_next    = wl_reg;
        tra_next   = tra_reg;
        vsp_next   = vsp_reg;
        pm_next    = pm_reg;
        pr_next    = pr_reg;
        op_next    = op_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        fpidx_next = fpidx_reg;
        epc_next   = epc_reg;
        res_next   = res_reg;
        rf_start   = '0;
        rf_wr      = '0;
        rd_addr    = fpidx_reg;
        add_a      = tra_reg;
        add_b      = 32'd4;
        add_ci     = 1'b0;

        case (ctl_reg)
            C_WAIT:
            begin
                if (in_acc)
                begin
                    case (in_data.command)
                        CMD_START:
                        begin
                            rf_start.en    = 1'b1;
                            rf_start.thumb = in_data.frame_pc[0];
                            rf_start.fp    = in_data.frame_fp;
                            rf_start.sp    = in_data.frame_sp;
                            rf_start.lr    = in_data.frame_lr;
                            epc_next   = in_data.frame_pc;
                            fpidx_next = in_data.frame_pc[0] ? REG_FP_THUMB : REG_FP_ARM;
                            lo_next    = in_data.frame_sp;
                            hi_next    = in_data.stack_top;
                            wl_next    = 9'd0;
                            bp_next    = 2'd0;
                            phase_next = PH_INDEX;
                        end
                        CMD_INDEX:
                        begin
                            if (phase_reg == PH_INDEX)
                            begin
                                add_a = in_data.index_entry_addr;
                                add_b = {in_data.index_word[30], in_data.index_word[30:0]};
                                if (in_data.index_word == 32'd1)
                                begin
                                    res_next   = mk_fail(FC_CANNOT);
                                    phase_next = PH_IDLE;
                                    ctl_next   = C_EMIT;
                                end
                                else if (!in_data.index_word[31])
                                begin
                                    tra_next   = add_sum;
                                    res_next   = mk_read(add_sum);
                                    phase_next = PH_FIRST;
                                    ctl_next   = C_EMIT;
                                end
                                else if (in_data.index_word[31:24] == 8'h80)
                                begin
                                    cur_next = in_data.index_word;
                                    ctl_next = C_BEGIN;
                                end
                                else
                                begin
                                    res_next   = mk_fail(FC_BAD_INDEX);
                                    phase_next = PH_IDLE;
                                    ctl_next   = C_EMIT;
                                end
                            end
                        end
                        CMD_MEM:
                        begin
                            case (phase_reg)
                                PH_FIRST:
                                begin
                                    cur_next = in_data.mem_word;
                                    tra_next = add_sum;
                                    ctl_next = C_BEGIN;
                                end
                                PH_OPWORD:
                                begin
                                    cur_next = in_data.mem_word;
                                    bp_next  = 2'd3;
                                    tra_next = add_sum;
                                    ctl_next = C_DISPATCH;
                                end
                                PH_ARGWORD:
                                begin
                                    cur_next = in_data.mem_word;
                                    bp_next  = 2'd3;
                                    tra_next = add_sum;
                                    ctl_next = C_ARG;
                                end
                                PH_POP:
                                begin
                                    rf_wr.en   = 1'b1;
                                    rf_wr.addr = pr_reg;
                                    rf_wr.data = in_data.mem_word;
                                    add_a      = vsp_reg;
                                    vsp_next   = add_sum;
                                    pm_next    = pm_reg >> 1;
                                    pr_next    = pr_reg + 4'd1;
                                    ctl_next   = C_POP;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            C_BEGIN:
            begin
                if (cur_reg[31:24] == 8'h80)
                begin
                    bp_next  = 2'd2;
                    wl_next  = 9'd1;
                    ctl_next = C_FETCH;
                end
                else if (cur_reg[31:24] == 8'h81)
                begin
                    bp_next  = 2'd1;
                    wl_next  = {1'b0, cur_reg[23:16]} + 9'd1;
                    ctl_next = C_FETCH;
                end
                else
                begin
                    res_next   = mk_fail(FC_BAD_PERS);
                    phase_next = PH_IDLE;
                    ctl_next   = C_EMIT;
                end
            end
            C_FETCH:
            begin
                op_next = nb_byte;
                wl_next = nb_wl;
                bp_next = nb_bp;
                if (nb_fetch)
                begin
                    res_next   = mk_read(tra_reg);
                    phase_next = PH_OPWORD;
                    ctl_next   = C_EMIT;
                end
                else
                begin
                    ctl_next = C_DISPATCH;
                end
            end
            C_DISPATCH:
            begin
                rd_addr = op_reg[3:0];
                add_a   = r13;
                if (op_reg[7:4] == 4'h8 || op_reg == OP_POP_LOW || op_reg == OP_VSP_LONG)
                begin
                    pm_next = {4'b0, nb_byte};
                    wl_next = nb_wl;
                    bp_next = nb_bp;
                    if (nb_fetch)
                    begin
                        res_next   = mk_read(tra_reg);
                        phase_next = PH_ARGWORD;
                        ctl_next   = C_EMIT;
                    end
                    else
                    begin
                        ctl_next = C_ARG;
                    end
                end
                else if (op_reg[7:6] == 2'b00)
                begin
                    add_b      = {23'b0, {1'b0, op_reg[5:0]} + 7'd1, 2'b00};
                    rf_wr.en   = 1'b1;
                    rf_wr.addr = REG_SP;
                    rf_wr.data = add_sum;
                    ctl_next   = C_DONE;
                end
                else if (op_reg[7:6] == 2'b01)
                begin
                    add_b      = ~{23'b0, {1'b0, op_reg[5:0]} + 7'd1, 2'b00};
                    add_ci     = 1'b1;
                    rf_wr.en   = 1'b1;
                    rf_wr.addr = REG_SP;
                    rf_wr.data = add_sum;
                    ctl_next   = C_DONE;
                end
                else if (op_reg[7:4] == 4'h9 && (op_reg & 8'h0d) != 8'h0d)
                begin
                    rf_wr.en   = 1'b1;
                    rf_wr.addr = REG_SP;
                    rf_wr.data = rd_data;
                    ctl_next   = C_DONE;
                end
                else if (op_reg[7:4] == 4'ha)
                begin
                    pm_next  = {1'b0, op_reg[3], 2'b00, 8'hff >> (3'd7 - op_reg[2:0])};
                    pr_next  = 4'd4;
                    vsp_next = r13;
                    ctl_next = C_POP;
                end
                else if (op_reg == OP_FINISH)
                begin
                    if (r15 == 32'd0)
                    begin
                        rf_wr.en   = 1'b1;
                        rf_wr.addr = REG_PC;
                        rf_wr.data = r14;
                    end
                    wl_next  = 9'd0;
                    ctl_next = C_DONE;
                end
                else
                begin
                    res_next   = mk_fail(FC_UNHANDLED);
                    phase_next = PH_IDLE;
                    ctl_next   = C_EMIT;
                end
            end
            C_ARG:
            begin
                add_a = r13;
                add_b = {21'b0, {1'b0, arg_b} + 9'h081, 2'b00};
                if (op_reg == OP_VSP_LONG)
                begin
                    rf_wr.en   = 1'b1;
                    rf_wr.addr = REG_SP;
                    rf_wr.data = add_sum;
                    ctl_next   = C_DONE;
                end
                else if (op_reg == OP_POP_LOW)
                begin
                    if (arg_b == 8'd0 || arg_b[7:4] != 4'd0)
                    begin
                        res_next   = mk_fail(FC_SPARE);
                        phase_next = PH_IDLE;
                        ctl_next   = C_EMIT;
                    end
                    else
                    begin
                        pm_next  = {4'b0, arg_b};
                        pr_next  = 4'd0;
                        vsp_next = r13;
                        ctl_next = C_POP;
                    end
                end
                else
                begin
                    pm_next = {op_reg[3:0], arg_b};
                    if ({op_reg[3:0], arg_b} == 12'd0)
                    begin
                        res_next   = mk_fail(FC_REFUSE);
                        phase_next = PH_IDLE;
                        ctl_next   = C_EMIT;
                    end
                    else
                    begin
                        pr_next  = 4'd4;
                        vsp_next = r13;
                        ctl_next = C_POP;
                    end
                end
            end
            C_POP:
            begin
                if (pm_reg == 12'd0)
                begin
                    if (!(op_reg[7:4] == 4'h8 && op_reg[1]))
                    begin
                        rf_wr.en   = 1'b1;
                        rf_wr.addr = REG_SP;
                        rf_wr.data = vsp_reg;
                    end
                    ctl_next = C_DONE;
                end
                else if (!pm_reg[0])
                begin
                    pm_next = pm_reg >> 1;
                    pr_next = pr_reg + 4'd1;
                end
                else
                begin
                    res_next   = mk_read(vsp_reg);
                    phase_next = PH_POP;
                    ctl_next   = C_EMIT;
                end
            end
            C_DONE:
            begin
                if (r13 < lo_reg || r13 >= hi_reg)
                begin
                    res_next   = mk_fail(FC_SP_RANGE);
                    phase_next = PH_IDLE;
                    ctl_next   = C_EMIT;
                end
                else if (wl_reg == 9'd0)
                begin
                    ctl_next = C_COMPLETE;
                end
                else
                begin
                    ctl_next = C_FETCH;
                end
            end
            C_COMPLETE:
            begin
                rd_addr = fpidx_reg;
                if (r15 == 32'd0)
                begin
                    rf_wr.en   = 1'b1;
                    rf_wr.addr = REG_PC;
                    rf_wr.data = r14;
                end
                phase_next = PH_IDLE;
                ctl_next   = C_EMIT;
                if (pc_eff == epc_reg)
                begin
                    res_next = mk_fail(FC_PC_SAME);
                end
                else
                begin
                    res_next = '0;
                    res_next.result_kind = RK_FRAME;
                    res_next.new_fp = rd_data;
                    res_next.new_sp = r13;
                    res_next.new_lr = r14;
                    res_next.new_pc = pc_eff;
                end
            end
            C_EMIT:
            begin
                if (res_take)
                    ctl_next = C_WAIT;
            end
            default:
            begin
                ctl_next = C_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg   <= C_WAIT;
            phase_reg <= PH_IDLE;
            cur_reg   <= '0;
            bp_reg    <= '0;
            wl_reg    <= '0;
            tra_reg   <= '0;
            vsp_reg   <= '0;
            pm_reg    <= '0;
            pr_reg    <= '0;
            op_reg    <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            fpidx_reg <= REG_FP_ARM;
            epc_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            ctl_reg   <= ctl_next;
            phase_reg <= phase_next;
            cur_reg   <= cur_next;
            bp_reg    <= bp_next;
            wl_reg    <= wl_next;
            tra_reg   <= tra_next;
            vsp_reg   <= vsp_next;
            pm_reg    <= pm_next;
            pr_reg    <= pr_next;
            op_reg    <= op_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            fpidx_reg <= fpidx_next;
            epc_reg   <= epc_next;
            res_reg   <= res_next;
        end
    end

    a_read_has_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_reg.result_kind == RK_READ |->
        phase_reg == PH_FIRST || phase_reg == PH_OPWORD ||
        phase_reg == PH_ARGWORD || phase_reg == PH_POP)
        else $error("read request without pending phase");

    a_end_is_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_reg.result_kind != RK_READ |-> phase_reg == PH_IDLE)
        else $error("final result while run still open");

    a_pop_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_data.command == CMD_MEM && phase_reg == PH_POP |=>
        vsp_reg == $past(vsp_reg) + 32'd4)
        else $error("vsp did not advance on pop beat");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_reg.result_kind == RK_READ ||
        res_reg.result_kind == RK_FRAME || res_reg.result_kind == RK_FAIL)
        else $error("bad result kind");

endmodule

// ----- rtl/ehabi_unwind_interpreter.sv -----
// Top level of the EHABI unwind interpreter: sequencer, register file, output register.
//
// Input channel (in_valid/in_ready/in_data) carries start, index word and
// memory reply beats. Output channel (out_valid/out_ready/out_data) carries
// read requests, the unwound frame, or a failure code.
// A start beat gives no result. An index or reply beat
// runs the bytecode sequencer, one step per cycle through a single shared
// adder; the steps grow with the number of opcodes and, for a sparse pop
// mask, with its bits (one step per mask bit) handled before the next read.
// The result is then moved from the sequencer to the output register.
// in_ready is low while the sequencer runs and while a result waits to be
// moved; a result in the output register does not block the next beat.
// Reset clears the register file and returns the block to idle with no
// frame in progress. When the receiver stalls, the output beat holds and the
// sequencer waits with its next result.
module ehabi_unwind_interpreter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  eui_pkg::eui_in_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output eui_pkg::eui_out_t   out_data
);
    import eui_pkg::*;

    rf_start_t   rf_start;
    rf_wr_t      rf_wr;
    logic [3:0]  rd_addr;
    logic [31:0] rd_data, r13, r14, r15;
    logic        res_valid, res_take;
    eui_out_t    res;
    logic        out_valid_reg;
    eui_out_t    out_data_reg;

    eui_regfile u_rf (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (rf_start),
        .wr      (rf_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .r13     (r13),
        .r14     (r14),
        .r15     (r15)
    );

    eui_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .rf_start  (rf_start),
        .rf_wr     (rf_wr),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .r13       (r13),
        .r14       (r14),
        .r15       (r15)
    );

    assign res_take = res_valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_take)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
